@@ hdl/udiv_pkg.sv @@
// Shared types and constants for the unsigned restoring divider.
// Depends on nothing; used by the top level and by its port checker.
`default_nettype none

package udiv_pkg;

   // Width of each data field on the stream ports.
   localparam int unsigned FIELD_W    = 32;
   // Input tdata carries dividend (low) and divisor (high).
   localparam int unsigned REQ_DATA_W = 2 * FIELD_W;
   localparam int unsigned RSP_DATA_W = FIELD_W;

   // Command carried on req_tuser: which result to return.
   typedef enum logic {
      CMD_REMAINDER = 1'b0,
      CMD_QUOTIENT  = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/unsigned_restoring_divider_top.sv @@
// Top level of the pipelined unsigned restoring divider.
// Depends on udiv_pkg for field widths and the command encoding.
`default_nettype none

// Radix-2 restoring divider, one quotient bit per pipeline stage. Each
// transfer on the req_ side carries a dividend, a divisor and a command
// (remainder or quotient); each transfer on the rsp_ side returns the chosen
// value and a divide-by-zero flag. Operands are taken at WIDTH bits (upper
// port bits ignored, or zero-extended when WIDTH exceeds the 32-bit fields);
// the answer is WIDTH bits cut or zero-extended to 32. A zero divisor returns
// all ones in WIDTH bits for either command and sets the flag. One item can
// enter every clock cycle while the output does not stall. The pipe holds
// an operand register, WIDTH subtract-and-shift stages, an output register.
// The critical path is one (WIDTH+1)-bit subtract and select per stage.
// Each stage holds its item until the next is free, so bubbles collapse and
// a stalled output still lets new items fill the pipe behind it.
module unsigned_restoring_divider_top #(
   parameter int unsigned WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // req_tdata, from bit 0: dividend[31:0], divisor[63:32]
   input  wire  [udiv_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: command (0 remainder, 1 quotient)
   input  wire                                 req_tuser,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // rsp_tdata, from bit 0: answer[31:0]
   output logic [udiv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: divide_by_zero
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready
);

   localparam int unsigned FW = udiv_pkg::FIELD_W;

   // Per-stage pipeline registers; stage 0 is the operand register and
   // stage k (1..WIDTH) holds the state after k division steps.
   logic [WIDTH-1:0]  rem_ff  [0:WIDTH];   // partial remainder
   logic [WIDTH-1:0]  nq_ff   [0:WIDTH];   // dividend bits left, quotient bits in
   logic [WIDTH-1:0]  den_ff  [0:WIDTH];   // divisor
   udiv_pkg::cmd_type cmd_ff  [0:WIDTH];
   logic              dz_ff   [0:WIDTH];   // divisor was zero
   logic              vld_ff  [0:WIDTH];
   logic              stg_rdy [0:WIDTH];   // stage may take a new item

   logic [FW-1:0]     ans_ff;
   logic              ans_dz_ff;
   logic              ans_vld_ff;
   logic              out_rdy;

   logic [WIDTH-1:0]  num_in;
   logic [WIDTH-1:0]  den_in;
   logic [WIDTH-1:0]  res_w;
   logic [FW-1:0]     ans_in;

   // Output register is free when empty or when its transfer completes.
   assign out_rdy = !ans_vld_ff || rsp_tready;

   // Ready ripples back: a stage is free if empty or if it empties this cycle.
   always_comb begin
      stg_rdy[WIDTH] = !vld_ff[WIDTH] || out_rdy;
      for (int k = WIDTH - 1; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
   end

   assign req_tready = stg_rdy[0];

   // Fit the 32-bit port fields to WIDTH bits.
   generate
      if (WIDTH > FW) begin : g_in_wide
         assign num_in = {{(WIDTH-FW){1'b0}}, req_tdata[FW-1:0]};
         assign den_in = {{(WIDTH-FW){1'b0}}, req_tdata[2*FW-1:FW]};
      end else begin : g_in_narrow
         assign num_in = req_tdata[WIDTH-1:0];
         assign den_in = req_tdata[FW+WIDTH-1:FW];
      end
   endgenerate

   // Stage 0: capture operands, flag a zero divisor early.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (stg_rdy[0]) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= num_in;
         den_ff[0] <= den_in;
         cmd_ff[0] <= udiv_pkg::cmd_type'(req_tuser);
         dz_ff[0]  <= (den_in == '0);
      end
   end

   // Stages 1..WIDTH: shift in the next dividend bit, trial subtract,
   // keep the difference when it does not borrow.
   generate
      for (genvar k = 1; k <= WIDTH; k++) begin : g_step
         logic [WIDTH:0]   wide;
         logic [WIDTH+1:0] diff;
         logic             take;
         logic [WIDTH-1:0] rem_in;
         logic [WIDTH-1:0] nq_in;

         assign wide   = {rem_ff[k-1], nq_ff[k-1][WIDTH-1]};
         assign diff   = {1'b0, wide} - {2'b00, den_ff[k-1]};
         assign take   = !diff[WIDTH+1];
         assign rem_in = take ? diff[WIDTH-1:0] : wide[WIDTH-1:0];
         assign nq_in  = {nq_ff[k-1][WIDTH-2:0], take};

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (stg_rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (stg_rdy[k]) begin
               rem_ff[k] <= rem_in;
               nq_ff[k]  <= nq_in;
               den_ff[k] <= den_ff[k-1];
               cmd_ff[k] <= cmd_ff[k-1];
               dz_ff[k]  <= dz_ff[k-1];
            end
         end
      end
   endgenerate

   // Pick the result; a zero divisor forces all ones.
   always_comb begin
      if (dz_ff[WIDTH]) begin
         res_w = '1;
      end else if (cmd_ff[WIDTH] == udiv_pkg::CMD_QUOTIENT) begin
         res_w = nq_ff[WIDTH];
      end else begin
         res_w = rem_ff[WIDTH];
      end
   end

   generate
      if (WIDTH >= FW) begin : g_out_wide
         assign ans_in = res_w[FW-1:0];
      end else begin : g_out_narrow
         assign ans_in = {{(FW-WIDTH){1'b0}}, res_w};
      end
   endgenerate

   // Output register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         ans_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         ans_vld_ff <= vld_ff[WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         ans_ff    <= ans_in;
         ans_dz_ff <= dz_ff[WIDTH];
      end
   end

   assign rsp_tdata  = ans_ff;
   assign rsp_tuser  = ans_dz_ff;
   assign rsp_tvalid = ans_vld_ff;

endmodule

`default_nettype wire

@@ hdl/udiv_port_checker.sv @@
// Port-level checks for the unsigned restoring divider, with its bind.
// Depends on udiv_pkg and on unsigned_restoring_divider_top.
`default_nettype none

module udiv_port_checker #(
   parameter int unsigned WIDTH = 32
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tready,
   input wire [udiv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                              rsp_tuser,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready
);

   localparam int unsigned FW = udiv_pkg::FIELD_W;
   // All ones in WIDTH bits, seen through the 32-bit answer field.
   localparam logic [FW-1:0] ANS_ONES =
      (WIDTH >= FW) ? {FW{1'b1}} : FW'((64'd1 << WIDTH) - 64'd1);

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

   // A zero divisor answer is all ones in WIDTH bits.
   a_dz_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == ANS_ONES)
      else $error("divide-by-zero answer is not all ones");

   // No answer bits above WIDTH.
   a_ans_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata & ~ANS_ONES) == '0)
      else $error("answer has bits above WIDTH");

   // With the output empty the pipe must be free to take a transfer.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held off although the output is empty");

endmodule

bind unsigned_restoring_divider_top udiv_port_checker #(
   .WIDTH (WIDTH)
) u_udiv_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
